// File: src/ecpb_pkg.sv
// ----------------------------------------------------------------------------
// ecpb_pkg
// Shared constants, types and curve decode for the easing curve core.
// ----------------------------------------------------------------------------
package ecpb_pkg;

  // default fraction width, unsigned Q1.15
  localparam int unsigned ECPB_FRAC_BITS = 15;

  // fixed port widths
  localparam int unsigned PROG_W  = 16;
  localparam int unsigned EASED_W = 16;
  localparam int unsigned CURVE_W = 4;

  // multiply cells in the chain: quintic needs four products
  localparam int unsigned N_CELLS = 4;

  // curve select codes
  localparam logic [CURVE_W-1:0] CURVE_LINEAR       = 4'd0;
  localparam logic [CURVE_W-1:0] CURVE_QUAD_IN      = 4'd1;
  localparam logic [CURVE_W-1:0] CURVE_QUAD_OUT     = 4'd2;
  localparam logic [CURVE_W-1:0] CURVE_QUAD_INOUT   = 4'd3;
  localparam logic [CURVE_W-1:0] CURVE_CUBIC_IN     = 4'd4;
  localparam logic [CURVE_W-1:0] CURVE_CUBIC_OUT    = 4'd5;
  localparam logic [CURVE_W-1:0] CURVE_CUBIC_INOUT  = 4'd6;
  localparam logic [CURVE_W-1:0] CURVE_QUART_IN     = 4'd7;
  localparam logic [CURVE_W-1:0] CURVE_QUART_OUT    = 4'd8;
  localparam logic [CURVE_W-1:0] CURVE_QUART_INOUT  = 4'd9;
  localparam logic [CURVE_W-1:0] CURVE_QUINT_IN     = 4'd10;
  localparam logic [CURVE_W-1:0] CURVE_QUINT_OUT    = 4'd11;
  localparam logic [CURVE_W-1:0] CURVE_QUINT_INOUT  = 4'd12;
  localparam logic [CURVE_W-1:0] CURVE_BOUNCE_IN    = 4'd13;
  localparam logic [CURVE_W-1:0] CURVE_BOUNCE_OUT   = 4'd14;
  localparam logic [CURVE_W-1:0] CURVE_BOUNCE_INOUT = 4'd15;

  typedef enum logic [2:0] {
    FORM_LINEAR,
    FORM_IN,
    FORM_OUT,
    FORM_INOUT,
    FORM_BNC_IN,
    FORM_BNC_OUT,
    FORM_BNC_INOUT
  } form_e;

  // control carried alongside each item down the chain
  typedef struct packed {
    form_e      form;
    logic       low_half;   // t below one half
    logic [2:0] mul_left;   // products still to form
    logic [2:0] scale_sh;   // in-out scale, log2
  } tag_t;

  function automatic tag_t curve_decode(input logic [CURVE_W-1:0] sel,
                                        input logic low_half);
    tag_t tag;
    tag.low_half = low_half;
    case (sel)
      CURVE_LINEAR: tag.form = FORM_LINEAR;
      CURVE_QUAD_IN, CURVE_CUBIC_IN, CURVE_QUART_IN, CURVE_QUINT_IN:
        tag.form = FORM_IN;
      CURVE_QUAD_OUT, CURVE_CUBIC_OUT, CURVE_QUART_OUT, CURVE_QUINT_OUT:
        tag.form = FORM_OUT;
      CURVE_QUAD_INOUT, CURVE_CUBIC_INOUT, CURVE_QUART_INOUT, CURVE_QUINT_INOUT:
        tag.form = FORM_INOUT;
      CURVE_BOUNCE_IN:  tag.form = FORM_BNC_IN;
      CURVE_BOUNCE_OUT: tag.form = FORM_BNC_OUT;
      default:          tag.form = FORM_BNC_INOUT;
    endcase
    case (sel)
      CURVE_LINEAR: tag.mul_left = 3'd0;
      CURVE_QUAD_IN, CURVE_QUAD_OUT, CURVE_QUAD_INOUT: tag.mul_left = 3'd1;
      CURVE_CUBIC_IN, CURVE_CUBIC_OUT, CURVE_CUBIC_INOUT: tag.mul_left = 3'd2;
      CURVE_QUART_IN, CURVE_QUART_OUT, CURVE_QUART_INOUT: tag.mul_left = 3'd3;
      CURVE_QUINT_IN, CURVE_QUINT_OUT, CURVE_QUINT_INOUT: tag.mul_left = 3'd4;
      default: tag.mul_left = 3'd1;  // bounce: square only
    endcase
    tag.scale_sh = tag.mul_left;
    return tag;
  endfunction

endpackage

// File: src/easing_curve_polynomial_bounce_core.sv
// ----------------------------------------------------------------------------
// easing_curve_polynomial_bounce_core
// Easing curve evaluator: linear, polynomial and bounce curves in Q1.15.
// ----------------------------------------------------------------------------
// Takes one progress item per clock while the output is drained and returns
// its eased value through a front stage, a chain of four multiply cells, a
// bounce coefficient stage and an output register. Each cell forms one
// rounded product, so the chain of cells sets the latency. Stages hold their
// item while the next one is full, so the input stalls only when every stage
// up to the front is occupied. Progress above one is clamped to one and the
// result is saturated to 0..one. The curve is picked by the single config
// register, written through the config channel (always ready); the user
// writes it only while no item is in flight, which the block itself does not
// enforce; items already inside carry their decoded curve with them.
// ----------------------------------------------------------------------------
module easing_curve_polynomial_bounce_core import ecpb_pkg::*; #(
  parameter int unsigned FRAC_BITS = ECPB_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CURVE_W-1:0] cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PROG_W-1:0]  progress_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [EASED_W-1:0] eased_value_o
);

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned RW = FRAC_BITS + 6;
  localparam int unsigned CW = FRAC_BITS + 5;

  // curve select register
  logic [CURVE_W-1:0] curve_q;

  // chain links: index 0 is the front stage output, N_CELLS the last cell
  logic          ch_vld [N_CELLS+1];
  logic          ch_rdy [N_CELLS+1];
  logic [VW-1:0] ch_p   [N_CELLS+1];
  logic [VW-1:0] ch_x   [N_CELLS+1];
  tag_t          ch_tag [N_CELLS+1];

  logic          prep_rdy;

  // bounce stage to output stage
  logic          bnc_vld;
  logic          bnc_rdy;
  logic [VW-1:0] bnc_p;
  logic [RW-1:0] bnc_ra;
  logic [RW-1:0] bnc_rb;
  logic [CW-1:0] bnc_c;
  tag_t          bnc_tag;

  logic          fin_rdy;
  logic [VW-1:0] eased;

  // config is taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q <= CURVE_LINEAR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      curve_q <= cfg_data_i;
    end
  end

  // clamp, base select and curve decode
  ecpb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (prep_rdy),
    .curve_i    (curve_q),
    .progress_i (progress_i),
    .valid_o    (ch_vld[0]),
    .ready_i    (ch_rdy[0]),
    .p_o        (ch_p[0]),
    .x_o        (ch_x[0]),
    .tag_o      (ch_tag[0])
  );

  assign in_stall_o = !prep_rdy;

  // power chain, one rounded product per cell
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    ecpb_pow_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ch_vld[i]),
      .ready_o (ch_rdy[i]),
      .p_i     (ch_p[i]),
      .x_i     (ch_x[i]),
      .tag_i   (ch_tag[i]),
      .valid_o (ch_vld[i+1]),
      .ready_i (ch_rdy[i+1]),
      .p_o     (ch_p[i+1]),
      .x_o     (ch_x[i+1]),
      .tag_o   (ch_tag[i+1])
    );
  end

  // bounce segment pick and coefficient products
  ecpb_bounce #(.FRAC_BITS(FRAC_BITS)) u_bounce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ch_vld[N_CELLS]),
    .ready_o (ch_rdy[N_CELLS]),
    .p_i     (ch_p[N_CELLS]),
    .x_i     (ch_x[N_CELLS]),
    .tag_i   (ch_tag[N_CELLS]),
    .valid_o (bnc_vld),
    .ready_i (bnc_rdy),
    .p_o     (bnc_p),
    .ra_o    (bnc_ra),
    .rb_o    (bnc_rb),
    .c_o     (bnc_c),
    .tag_o   (bnc_tag)
  );

  // curve form, saturation, output register
  ecpb_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bnc_vld),
    .ready_o (bnc_rdy),
    .p_i     (bnc_p),
    .ra_i    (bnc_ra),
    .rb_i    (bnc_rb),
    .c_i     (bnc_c),
    .tag_i   (bnc_tag),
    .valid_o (out_valid_o),
    .ready_i (fin_rdy),
    .eased_o (eased)
  );

  assign fin_rdy = !out_stall_i;

  // wider formats keep only the low bits
  assign eased_value_o = EASED_W'(eased);

`ifndef SYNTHESIS
  // an empty output register lets every stage move, so input never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with output register empty");

  // a stall at the input means the front stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ch_vld[0])
    else $error("input stalled with empty front stage");

  // config write lands in the curve register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> curve_q == $past(cfg_data_i))
    else $error("curve select write lost");

  // results never exceed one in the native format
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (FRAC_BITS > 15) || (32'(eased_value_o) <= (32'd1 << FRAC_BITS)))
    else $error("eased value above one");
`endif

endmodule

// File: src/ecpb_prep.sv
// ----------------------------------------------------------------------------
// ecpb_prep
// Front stage: clamps progress, picks the base value and decodes the curve.
// ----------------------------------------------------------------------------
module ecpb_prep import ecpb_pkg::*; #(
  parameter int unsigned FRAC_BITS = ECPB_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [CURVE_W-1:0]   curve_i,
  input  logic [PROG_W-1:0]    progress_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [FRAC_BITS:0]   p_o,
  output logic [FRAC_BITS:0]   x_o,
  output tag_t                 tag_o
);

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned TW = (VW > PROG_W) ? VW : PROG_W;
  localparam logic [TW-1:0] ONE_T = TW'(64'd1 << FRAC_BITS);
  localparam logic [VW-1:0] ONE_V = VW'(64'd1 << FRAC_BITS);
  localparam logic [VW-1:0] HALF_V = ONE_V >> 1;

  logic [TW-1:0] prog_ext;
  logic [TW-1:0] t_clamp;
  logic [VW-1:0] t;
  logic [VW-1:0] u;
  logic          low_half;
  logic [VW:0]   two_t;
  logic [VW:0]   d_lo;
  logic [VW:0]   d_hi;
  tag_t          tag;
  logic [VW-1:0] x_sel;

  logic          vld_q;
  logic [VW-1:0] x_q;
  tag_t          tag_q;

  always_comb begin
    prog_ext = TW'(progress_i);
    t_clamp  = (prog_ext > ONE_T) ? ONE_T : prog_ext;
    t        = VW'(t_clamp);
    u        = ONE_V - t;
    low_half = (t < HALF_V);
    two_t    = {t, 1'b0};
    d_lo     = {1'b0, ONE_V} - two_t;
    d_hi     = two_t - {1'b0, ONE_V};
    tag      = curve_decode(curve_i, low_half);
    case (tag.form)
      FORM_OUT, FORM_BNC_IN: x_sel = u;
      FORM_INOUT:            x_sel = low_half ? t : u;
      FORM_BNC_INOUT:        x_sel = low_half ? VW'(d_lo) : VW'(d_hi);
      default:               x_sel = t;
    endcase
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q   <= x_sel;
      tag_q <= tag;
    end
  end

  assign valid_o = vld_q;
  assign p_o     = x_q;
  assign x_o     = x_q;
  assign tag_o   = tag_q;

endmodule

// File: src/ecpb_pow_cell.sv
// ----------------------------------------------------------------------------
// ecpb_pow_cell
// Power chain link: multiplies the running product by the base or passes it.
// ----------------------------------------------------------------------------
module ecpb_pow_cell import ecpb_pkg::*; #(
  parameter int unsigned FRAC_BITS = ECPB_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [FRAC_BITS:0] p_i,
  input  logic [FRAC_BITS:0] x_i,
  input  tag_t               tag_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [FRAC_BITS:0] p_o,
  output logic [FRAC_BITS:0] x_o,
  output tag_t               tag_o
);

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam logic [2*VW-1:0] RND = (2*VW)'(64'd1 << (FRAC_BITS - 1));

  logic [2*VW-1:0] prod;
  logic [2*VW-1:0] prod_r;
  logic [VW-1:0]   p_d;
  tag_t            tag_d;

  logic            vld_q;
  logic [VW-1:0]   p_q;
  logic [VW-1:0]   x_q;
  tag_t            tag_q;

  always_comb begin
    prod   = (2*VW)'(p_i) * (2*VW)'(x_i);
    prod_r = prod + RND;
    tag_d  = tag_i;
    if (tag_i.mul_left != 3'd0) begin
      p_d            = prod_r[FRAC_BITS +: VW];
      tag_d.mul_left = tag_i.mul_left - 3'd1;
    end else begin
      p_d = p_i;
    end
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      p_q   <= p_d;
      x_q   <= x_i;
      tag_q <= tag_d;
    end
  end

  assign valid_o = vld_q;
  assign p_o     = p_q;
  assign x_o     = x_q;
  assign tag_o   = tag_q;

endmodule

// File: src/ecpb_bounce.sv
// ----------------------------------------------------------------------------
// ecpb_bounce
// Bounce stage: picks the segment and forms the two coefficient products.
// ----------------------------------------------------------------------------
module ecpb_bounce import ecpb_pkg::*; #(
  parameter int unsigned FRAC_BITS = ECPB_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [FRAC_BITS:0]   p_i,
  input  logic [FRAC_BITS:0]   x_i,
  input  tag_t                 tag_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [FRAC_BITS:0]   p_o,
  output logic [FRAC_BITS+5:0] ra_o,
  output logic [FRAC_BITS+5:0] rb_o,
  output logic [FRAC_BITS+4:0] c_o,
  output tag_t                 tag_o
);

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned CW = FRAC_BITS + 5;
  localparam int unsigned PW = CW + VW;
  localparam int unsigned RW = CW + 1;
  localparam int unsigned XW = VW + 4;

  // coefficients, round(c * one) half up
  localparam logic [63:0] K1A_L = ((64'd121   << FRAC_BITS) + 64'd8)   / 64'd16;
  localparam logic [63:0] K2A_L = ((64'd363   << FRAC_BITS) + 64'd20)  / 64'd40;
  localparam logic [63:0] K2B_L = ((64'd99    << FRAC_BITS) + 64'd5)   / 64'd10;
  localparam logic [63:0] K2C_L = ((64'd17    << FRAC_BITS) + 64'd2)   / 64'd5;
  localparam logic [63:0] K3A_L = ((64'd4356  << FRAC_BITS) + 64'd180) / 64'd361;
  localparam logic [63:0] K3B_L = ((64'd35442 << FRAC_BITS) + 64'd902) / 64'd1805;
  localparam logic [63:0] K3C_L = ((64'd16061 << FRAC_BITS) + 64'd902) / 64'd1805;
  localparam logic [63:0] K4A_L = ((64'd54    << FRAC_BITS) + 64'd2)   / 64'd5;
  localparam logic [63:0] K4B_L = ((64'd513   << FRAC_BITS) + 64'd12)  / 64'd25;
  localparam logic [63:0] K4C_L = ((64'd268   << FRAC_BITS) + 64'd12)  / 64'd25;

  localparam logic [XW-1:0] BRK4 = XW'(64'd4 << FRAC_BITS);
  localparam logic [XW-1:0] BRK8 = XW'(64'd8 << FRAC_BITS);
  localparam logic [XW-1:0] BRK9 = XW'(64'd9 << FRAC_BITS);
  localparam logic [PW-1:0] RND  = PW'(64'd1 << (FRAC_BITS - 1));

  logic [XW-1:0] x_ext;
  logic [XW-1:0] x11;
  logic [XW-1:0] x10;
  logic [CW-1:0] ka;
  logic [CW-1:0] kb;
  logic [CW-1:0] kc;
  logic [PW-1:0] prod_a;
  logic [PW-1:0] prod_b;
  logic [PW-1:0] rnd_a;
  logic [PW-1:0] rnd_b;

  logic          vld_q;
  logic [VW-1:0] p_q;
  logic [RW-1:0] ra_q;
  logic [RW-1:0] rb_q;
  logic [CW-1:0] c_q;
  tag_t          tag_q;

  always_comb begin
    x_ext = XW'(x_i);
    x11   = (x_ext << 3) + (x_ext << 1) + x_ext;
    x10   = (x_ext << 3) + (x_ext << 1);
    if (x11 < BRK4) begin
      ka = CW'(K1A_L);
      kb = '0;
      kc = '0;
    end else if (x11 < BRK8) begin
      ka = CW'(K2A_L);
      kb = CW'(K2B_L);
      kc = CW'(K2C_L);
    end else if (x10 < BRK9) begin
      ka = CW'(K3A_L);
      kb = CW'(K3B_L);
      kc = CW'(K3C_L);
    end else begin
      ka = CW'(K4A_L);
      kb = CW'(K4B_L);
      kc = CW'(K4C_L);
    end
    // p carries x*x on the bounce curves
    prod_a = PW'(ka) * PW'(p_i);
    prod_b = PW'(kb) * PW'(x_i);
    rnd_a  = prod_a + RND;
    rnd_b  = prod_b + RND;
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      p_q   <= p_i;
      ra_q  <= rnd_a[FRAC_BITS +: RW];
      rb_q  <= rnd_b[FRAC_BITS +: RW];
      c_q   <= kc;
      tag_q <= tag_i;
    end
  end

  assign valid_o = vld_q;
  assign p_o     = p_q;
  assign ra_o    = ra_q;
  assign rb_o    = rb_q;
  assign c_o     = c_q;
  assign tag_o   = tag_q;

endmodule

// File: src/ecpb_finish.sv
// ----------------------------------------------------------------------------
// ecpb_finish
// Output stage: applies the curve form, saturates and holds the result.
// ----------------------------------------------------------------------------
module ecpb_finish import ecpb_pkg::*; #(
  parameter int unsigned FRAC_BITS = ECPB_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [FRAC_BITS:0]   p_i,
  input  logic [FRAC_BITS+5:0] ra_i,
  input  logic [FRAC_BITS+5:0] rb_i,
  input  logic [FRAC_BITS+4:0] c_i,
  input  tag_t                 tag_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [FRAC_BITS:0]   eased_o
);

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned RW = FRAC_BITS + 6;
  localparam int unsigned SW = RW + 2;
  localparam int unsigned EW = VW + 4;
  localparam logic [VW-1:0] ONE_V  = VW'(64'd1 << FRAC_BITS);
  localparam logic [VW-1:0] HALF_V = ONE_V >> 1;
  localparam logic [EW-1:0] ONE_E  = EW'(ONE_V);

  logic signed [SW-1:0] v;
  logic [VW-1:0]        bo;
  logic [EW-1:0]        scaled;
  logic [VW-1:0]        io_lo;
  logic [VW-1:0]        io_hi;
  logic [VW:0]          bi_lo;
  logic [VW:0]          bi_hi;
  logic [VW-1:0]        res;

  logic                 vld_q;
  logic [VW-1:0]        eased_q;

  always_comb begin
    // bounce out: a*x^2 - b*x + c, clipped to [0, one]
    v = $signed(SW'(ra_i)) - $signed(SW'(rb_i)) + $signed(SW'(c_i));
    if (v < 0) begin
      bo = '0;
    end else if (v > $signed(SW'(ONE_V))) begin
      bo = ONE_V;
    end else begin
      bo = VW'(v);
    end
    scaled = EW'(p_i) << tag_i.scale_sh;
    io_lo  = (scaled > ONE_E) ? ONE_V : VW'(scaled);
    io_hi  = (scaled > ONE_E) ? '0 : VW'(ONE_E - scaled);
    bi_lo  = ({1'b0, ONE_V} - {1'b0, bo} + (VW+1)'(1)) >> 1;
    bi_hi  = (({1'b0, bo} + (VW+1)'(1)) >> 1) + {1'b0, HALF_V};
    case (tag_i.form)
      FORM_OUT:       res = ONE_V - p_i;
      FORM_INOUT:     res = tag_i.low_half ? io_lo : io_hi;
      FORM_BNC_IN:    res = ONE_V - bo;
      FORM_BNC_OUT:   res = bo;
      FORM_BNC_INOUT: res = tag_i.low_half ? VW'(bi_lo) : VW'(bi_hi);
      default:        res = p_i;
    endcase
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      eased_q <= res;
    end
  end

  assign valid_o = vld_q;
  assign eased_o = eased_q;

endmodule
